[design/blp_pkg.sv]
`default_nettype none

package blp_pkg;

   // Fixed widths of the request and response fields
   localparam int COUNT_FIELD_WIDTH = 8;
   localparam int TIME_FIELD_WIDTH  = 16;

   // Defaults for the internal counter widths
   localparam int TIME_WIDTH_DEF  = 16;
   localparam int COUNT_WIDTH_DEF = 8;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OUTPUTS_ENABLED = 2'd0,
      CSR_BUZZER_PRESENT  = 2'd1,
      CSR_LED_PRESENT     = 2'd2,
      CSR_ACTIVE_HIGH     = 2'd3
   } csr_index_type;

   // Request kinds
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_PLAY = 1'b1;

   typedef struct packed {
      logic                         req_type;
      logic [COUNT_FIELD_WIDTH-1:0] pulse_count;
      logic [TIME_FIELD_WIDTH-1:0]  first_on_ms;
      logic [TIME_FIELD_WIDTH-1:0]  repeat_on_ms;
      logic [TIME_FIELD_WIDTH-1:0]  gap_ms;
      logic                         led_enable;
      logic [TIME_FIELD_WIDTH-1:0]  led_hold_ms;
   } req_payload_type;

   typedef struct packed {
      logic buzzer_level;
      logic led_level;
      logic busy_res;
   } rsp_payload_type;

   typedef struct packed {
      logic outputs_enabled;
      logic buzzer_present;
      logic led_present;
      logic active_high;
   } cfg_type;

   // Post-step flags handed from the engine to the response stage
   typedef struct packed {
      logic buzzer_on;
      logic led_on;
      logic playing;
   } status_type;

endpackage

`default_nettype wire

[design/blp_engine.sv]
`default_nettype none

module blp_engine #(
   parameter int TIME_WIDTH  = blp_pkg::TIME_WIDTH_DEF,
   parameter int COUNT_WIDTH = blp_pkg::COUNT_WIDTH_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step_en,
   input  blp_pkg::req_payload_type req,
   input  blp_pkg::cfg_type         cfg,
   output blp_pkg::status_type      status_next
);

   localparam logic [TIME_WIDTH-1:0]  TIME_MAX  = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [31:0] TIME_MAX_WIDE  = 32'(TIME_MAX);
   localparam logic [15:0] COUNT_MAX_WIDE = 16'(COUNT_MAX);

   logic                   buzzer_on_ff, buzzer_on_in;
   logic                   led_on_ff, led_on_in;
   logic                   playing_ff, playing_in;
   logic                   led_armed_ff, led_armed_in;
   logic [COUNT_WIDTH-1:0] pulses_left_ff, pulses_left_in;
   logic                   first_pending_ff, first_pending_in;
   logic [TIME_WIDTH-1:0]  phase_timer_ff, phase_timer_in;
   logic [TIME_WIDTH-1:0]  led_timer_ff, led_timer_in;
   logic [TIME_WIDTH-1:0]  first_on_ff, first_on_in;
   logic [TIME_WIDTH-1:0]  repeat_on_ff, repeat_on_in;
   logic [TIME_WIDTH-1:0]  gap_ff, gap_in;

   // Clamp a request time field into the timer width
   function automatic logic [TIME_WIDTH-1:0] sat_time(
      input logic [blp_pkg::TIME_FIELD_WIDTH-1:0] v
   );
      logic [31:0] wide;
      wide = 32'(v);
      return (wide > TIME_MAX_WIDE) ? TIME_MAX : TIME_WIDTH'(wide);
   endfunction

   logic [TIME_WIDTH-1:0]  hold_sat;
   logic [TIME_WIDTH-1:0]  led_dec;
   logic [TIME_WIDTH-1:0]  phase_dec;
   logic [COUNT_WIDTH-1:0] pulses_dec;
   logic [15:0]            count_wide;
   logic                   play_pulses;

   always_comb begin
      hold_sat    = sat_time(req.led_hold_ms);
      count_wide  = 16'(req.pulse_count);
      led_dec     = (led_timer_ff != '0) ? led_timer_ff - 1'b1 : '0;
      phase_dec   = (phase_timer_ff != '0) ? phase_timer_ff - 1'b1 : '0;
      pulses_dec  = (pulses_left_ff != '0) ? pulses_left_ff - 1'b1 : '0;
      play_pulses = (count_wide != '0);

      buzzer_on_in     = buzzer_on_ff;
      led_on_in        = led_on_ff;
      playing_in       = playing_ff;
      led_armed_in     = led_armed_ff;
      pulses_left_in   = pulses_left_ff;
      first_pending_in = first_pending_ff;
      phase_timer_in   = phase_timer_ff;
      led_timer_in     = led_timer_ff;
      first_on_in      = first_on_ff;
      repeat_on_in     = repeat_on_ff;
      gap_in           = gap_ff;

      if (step_en) begin
         if (req.req_type == blp_pkg::REQ_PLAY) begin
            first_on_in      = sat_time(req.first_on_ms);
            repeat_on_in     = sat_time(req.repeat_on_ms);
            gap_in           = sat_time(req.gap_ms);
            pulses_left_in   = (count_wide > COUNT_MAX_WIDE) ? COUNT_MAX
                                                             : COUNT_WIDTH'(count_wide);
            playing_in       = play_pulses;
            first_pending_in = 1'b1;
            led_armed_in     = req.led_enable && (hold_sat != '0);
            led_timer_in     = (req.led_enable && (hold_sat != '0)) ? hold_sat : '0;
            led_on_in        = req.led_enable && cfg.led_present;
            if (play_pulses && cfg.buzzer_present) begin
               buzzer_on_in   = 1'b1;
               phase_timer_in = sat_time(req.first_on_ms);
            end else begin
               buzzer_on_in   = 1'b0;
               phase_timer_in = '0;
            end
         end else begin
            // LED hold countdown runs while armed, lit or not
            if (led_armed_ff) begin
               led_timer_in = led_dec;
               if (led_on_ff && (led_dec == '0)) begin
                  led_on_in    = 1'b0;
                  led_armed_in = 1'b0;
               end
            end
            if (playing_ff) begin
               phase_timer_in = phase_dec;
               if (phase_dec == '0) begin
                  if (buzzer_on_ff) begin
                     buzzer_on_in = 1'b0;
                     if (pulses_left_ff != '0) begin
                        first_pending_in = 1'b0;
                     end
                     pulses_left_in = pulses_dec;
                     if (pulses_dec == '0) begin
                        playing_in     = 1'b0;
                        phase_timer_in = '0;
                     end else begin
                        phase_timer_in = gap_ff;
                     end
                  end else begin
                     buzzer_on_in   = 1'b1;
                     phase_timer_in = first_pending_ff ? first_on_ff : repeat_on_ff;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buzzer_on_ff     <= 1'b0;
         led_on_ff        <= 1'b0;
         playing_ff       <= 1'b0;
         led_armed_ff     <= 1'b0;
         pulses_left_ff   <= '0;
         first_pending_ff <= 1'b1;
         phase_timer_ff   <= '0;
         led_timer_ff     <= '0;
         first_on_ff      <= '0;
         repeat_on_ff     <= '0;
         gap_ff           <= '0;
      end else begin
         buzzer_on_ff     <= buzzer_on_in;
         led_on_ff        <= led_on_in;
         playing_ff       <= playing_in;
         led_armed_ff     <= led_armed_in;
         pulses_left_ff   <= pulses_left_in;
         first_pending_ff <= first_pending_in;
         phase_timer_ff   <= phase_timer_in;
         led_timer_ff     <= led_timer_in;
         first_on_ff      <= first_on_in;
         repeat_on_ff     <= repeat_on_in;
         gap_ff           <= gap_in;
      end
   end

   assign status_next.buzzer_on = buzzer_on_in;
   assign status_next.led_on    = led_on_in;
   assign status_next.playing   = playing_in;

endmodule

`default_nettype wire

[design/buzzer_led_pulse_pattern_player_top.sv]
`default_nettype none

// Buzzer / LED feedback pattern player. Every request yields exactly one
// response. A play request (req_type = 1) loads a pattern and restarts
// playback at once; a tick request (req_type = 0) stands for one
// millisecond and counts down the LED hold timer and the buzzer phase timer.
// The response carries the pin levels and the busy flag as they stand after
// that request. Timing: one request per clock while no response is stalled;
// each response is registered. All state is updated by a single
// combinational pass in blp_engine; the response register decouples the two
// sides, so a request is still taken while an earlier response waits, unless
// that response is stalled. Registers on the csr_ port (outputs_enabled,
// buzzer_present, led_present, active_high) take effect on the next request
// and do not restart playback. With outputs disabled or no pin present,
// requests leave the state alone but are still answered. Times wider than
// TIME_WIDTH and counts wider than COUNT_WIDTH saturate to all ones.
module buzzer_led_pulse_pattern_player_top #(
   parameter int TIME_WIDTH  = blp_pkg::TIME_WIDTH_DEF,
   parameter int COUNT_WIDTH = blp_pkg::COUNT_WIDTH_DEF
) (
   input  wire                                       clock,
   input  wire                                       reset,
   // request channel
   input  wire                                       req_valid,
   output logic                                      req_stall,
   input  blp_pkg::req_payload_type                  req_payload,
   // response channel
   output logic                                      rsp_valid,
   input  wire                                       rsp_stall,
   output blp_pkg::rsp_payload_type                  rsp_payload,
   // register write port
   input  wire                                       csr_we,
   input  wire [blp_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  wire [blp_pkg::CSR_DATA_WIDTH-1:0]         csr_wdata
);

   blp_pkg::cfg_type         cfg_ff, cfg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   blp_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;
   blp_pkg::status_type      status_next;
   logic                     req_accept;
   logic                     enabled;

   // Register file: last write wins, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (blp_pkg::csr_index_type'(csr_index))
            blp_pkg::CSR_OUTPUTS_ENABLED: cfg_in.outputs_enabled = csr_wdata[0];
            blp_pkg::CSR_BUZZER_PRESENT:  cfg_in.buzzer_present  = csr_wdata[0];
            blp_pkg::CSR_LED_PRESENT:     cfg_in.led_present     = csr_wdata[0];
            blp_pkg::CSR_ACTIVE_HIGH:     cfg_in.active_high     = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Accept whenever the response slot is free or being drained this cycle
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign enabled    = cfg_ff.outputs_enabled &&
                       (cfg_ff.buzzer_present || cfg_ff.led_present);

   blp_engine #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (req_accept && enabled),
      .req         (req_payload),
      .cfg         (cfg_ff),
      .status_next (status_next)
   );

   // Pin level: active level when present and on, idle level otherwise
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (req_accept) begin
         rsp_valid_in                = 1'b1;
         rsp_payload_in.buzzer_level =
            !((cfg_ff.buzzer_present && status_next.buzzer_on) ^ cfg_ff.active_high);
         rsp_payload_in.led_level    =
            !((cfg_ff.led_present && status_next.led_on) ^ cfg_ff.active_high);
         rsp_payload_in.busy_res     = status_next.playing;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.outputs_enabled <= 1'b0;
         cfg_ff.buzzer_present  <= 1'b0;
         cfg_ff.led_present     <= 1'b0;
         cfg_ff.active_high     <= 1'b1;
         rsp_valid_ff           <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[design/blp_checker.sv]
`default_nettype none

module blp_checker (
   input wire                           clock,
   input wire                           reset,
   input wire                           req_valid,
   input wire                           req_stall,
   input blp_pkg::req_payload_type      req_payload,
   input wire                           rsp_valid,
   input wire                           rsp_stall,
   input blp_pkg::rsp_payload_type      rsp_payload
);

   // Back-pressure only comes from a stalled response
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with no stalled response");

   // Every accepted request shows a response next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response");

   // No response invented without a request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && !req_stall) && !(rsp_valid && rsp_stall)) |=> !rsp_valid)
      else $error("response appeared without a request");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled response changed");

   // Stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=> (req_valid && $stable(req_payload)))
      else $error("stalled request changed");

endmodule

bind buzzer_led_pulse_pattern_player_top blp_checker u_blp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[verif/blp_level_monitor.sv]
`default_nettype none

// Watches the request, response and register ports of the pattern player,
// keeps its own copy of the pattern state and checks every response in order.
module blp_level_monitor
   import blp_pkg::*;
(
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_stall,
   input  req_payload_type                    req_payload,
   input  wire                                rsp_valid,
   input  wire                                rsp_stall,
   input  rsp_payload_type                    rsp_payload,
   input  wire                                csr_we,
   input  wire [CSR_INDEX_WIDTH-1:0]          csr_index,
   input  wire [CSR_DATA_WIDTH-1:0]           csr_wdata,
   output int                                 error_count,
   output int                                 pending_count
);

   cfg_type         settings;
   logic            beeping;
   logic            lit;
   logic            busy;
   logic            hold_armed;
   logic [7:0]      pulses_remaining;
   logic            first_pending;
   logic [15:0]     phase_count;
   logic [15:0]     hold_count;
   logic [15:0]     first_len;
   logic [15:0]     repeat_len;
   logic [15:0]     gap_len;

   rsp_payload_type expected_levels_q[$];
   int              mismatches = 0;
   int              waiting    = 0;
   int              responses  = 0;

   assign error_count   = mismatches;
   assign pending_count = waiting;

   task automatic flag_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH response %0d: %s", $time, responses, msg);
   endtask

   // Advances the pattern state by one request and returns the pin levels after it.
   function automatic rsp_payload_type advance_pattern(input req_payload_type r);
      rsp_payload_type levels;
      if (settings.outputs_enabled && (settings.buzzer_present || settings.led_present)) begin
         if (r.req_type == REQ_PLAY) begin
            first_len        = r.first_on_ms;
            repeat_len       = r.repeat_on_ms;
            gap_len          = r.gap_ms;
            pulses_remaining = r.pulse_count;
            busy             = (r.pulse_count != 0);
            first_pending    = 1'b1;
            hold_armed       = r.led_enable && (r.led_hold_ms != 0);
            hold_count       = hold_armed ? r.led_hold_ms : 16'd0;
            lit              = r.led_enable && settings.led_present;
            if (busy && settings.buzzer_present) begin
               beeping     = 1'b1;
               phase_count = first_len;
            end else begin
               beeping     = 1'b0;
               phase_count = 16'd0;
            end
         end else begin
            // LED hold runs down even while unlit; it only clears a lit LED
            if (hold_armed) begin
               if (hold_count != 0) hold_count--;
               if (lit && hold_count == 0) begin
                  lit        = 1'b0;
                  hold_armed = 1'b0;
               end
            end
            if (busy) begin
               if (phase_count != 0) phase_count--;
               if (phase_count == 0) begin
                  if (beeping) begin
                     beeping = 1'b0;
                     if (pulses_remaining != 0) begin
                        pulses_remaining--;
                        first_pending = 1'b0;
                     end
                     if (pulses_remaining == 0) begin
                        busy        = 1'b0;
                        phase_count = 16'd0;
                     end else begin
                        phase_count = gap_len;
                     end
                  end else begin
                     beeping     = 1'b1;
                     phase_count = first_pending ? first_len : repeat_len;
                  end
               end
            end
         end
      end
      levels.buzzer_level = (settings.buzzer_present && beeping) ?
                            settings.active_high : !settings.active_high;
      levels.led_level    = (settings.led_present && lit) ?
                            settings.active_high : !settings.active_high;
      levels.busy_res     = busy;
      return levels;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         settings         = '{outputs_enabled: 1'b0, buzzer_present: 1'b0,
                              led_present: 1'b0, active_high: 1'b1};
         beeping          = 1'b0;
         lit              = 1'b0;
         busy             = 1'b0;
         hold_armed       = 1'b0;
         pulses_remaining = '0;
         first_pending    = 1'b1;
         phase_count      = '0;
         hold_count       = '0;
         first_len        = '0;
         repeat_len       = '0;
         gap_len          = '0;
         expected_levels_q.delete();
         waiting          = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_OUTPUTS_ENABLED: settings.outputs_enabled = csr_wdata[0];
               CSR_BUZZER_PRESENT:  settings.buzzer_present  = csr_wdata[0];
               CSR_LED_PRESENT:     settings.led_present     = csr_wdata[0];
               CSR_ACTIVE_HIGH:     settings.active_high     = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            responses++;
            if (expected_levels_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected response %b", rsp_payload));
            end else begin
               want = expected_levels_q.pop_front();
               waiting--;
               if (rsp_payload.buzzer_level !== want.buzzer_level)
                  flag_mismatch($sformatf("buzzer_level got %b want %b",
                                          rsp_payload.buzzer_level, want.buzzer_level));
               if (rsp_payload.led_level !== want.led_level)
                  flag_mismatch($sformatf("led_level got %b want %b",
                                          rsp_payload.led_level, want.led_level));
               if (rsp_payload.busy_res !== want.busy_res)
                  flag_mismatch($sformatf("busy_res got %b want %b",
                                          rsp_payload.busy_res, want.busy_res));
            end
         end
         if (req_valid && !req_stall) begin
            expected_levels_q.push_back(advance_pattern(req_payload));
            waiting++;
         end
      end
   end

endmodule

`default_nettype wire

[verif/buzzer_led_pulse_pattern_player_top_tb.sv]
`default_nettype none

// Stimulus and verdict for the buzzer / LED pattern player. The monitor
// instance beside the block does all prediction and comparison; this module
// only drives requests, register writes and response back-pressure.
module buzzer_led_pulse_pattern_player_top_tb;
   import blp_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_OFF_LEN  = 300;   // long receiver stall, forces input stall
   localparam int ENABLED_CHUNK = 120;   // requests per enabled chunk
   localparam int IDLE_CHUNK    = 40;    // disabled chunks: block ignores requests

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_we      = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int error_count;
   int pending_count;
   int cycle_count  = 0;

   // idle rates in percent per cycle, changed per phase by the stimulus
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   logic hold_off_go = 1'b0;

   initial forever #2 clock = ~clock;

   buzzer_led_pulse_pattern_player_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   blp_level_monitor levels_mon (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Watchdog: a hung handshake or a lost response ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver back-pressure. A hold-off request from the stimulus stalls the
   // response side for a long stretch, counted here; otherwise random stalls.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            hold_off_go = 1'b0;
            stall_left  = HOLD_OFF_LEN;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Offers one request, with random sender gaps in front. Valid is left high
   // after acceptance so back-to-back requests never drop it within a step.
   task automatic send_request(input req_payload_type p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
   endtask

   // Drops valid and waits until every predicted response has come back;
   // the block gives one response per request.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   // Writes all four registers back to back; only called while idle.
   task automatic write_settings(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_OUTPUTS_ENABLED;
      csr_wdata <= c.outputs_enabled;
      @(posedge clock);
      csr_index <= CSR_BUZZER_PRESENT;
      csr_wdata <= c.buzzer_present;
      @(posedge clock);
      csr_index <= CSR_LED_PRESENT;
      csr_wdata <= c.led_present;
      @(posedge clock);
      csr_index <= CSR_ACTIVE_HIGH;
      csr_wdata <= c.active_high;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Tick with random junk in the fields the block ignores.
   function automatic req_payload_type tick_item();
      logic [95:0] raw;
      req_payload_type p;
      raw        = {$urandom, $urandom, $urandom};
      p          = raw[$bits(req_payload_type)-1:0];
      p.req_type = REQ_TICK;
      return p;
   endfunction

   function automatic req_payload_type play_item(input logic [7:0] count,
                                                 input logic [15:0] first_on,
                                                 input logic [15:0] repeat_on,
                                                 input logic [15:0] gap,
                                                 input logic led_en,
                                                 input logic [15:0] hold);
      req_payload_type p;
      p.req_type     = REQ_PLAY;
      p.pulse_count  = count;
      p.first_on_ms  = first_on;
      p.repeat_on_ms = repeat_on;
      p.gap_ms       = gap;
      p.led_enable   = led_en;
      p.led_hold_ms  = hold;
      return p;
   endfunction

   // Mostly short times so patterns finish inside a tick burst; now and then
   // a full-width value so every bit toggles.
   function automatic logic [15:0] pick_ms();
      return ($urandom_range(29) == 0) ? 16'($urandom) : 16'($urandom_range(5));
   endfunction

   function automatic req_payload_type random_play();
      logic [7:0] count;
      count = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(5));
      return play_item(count, pick_ms(), pick_ms(), pick_ms(), 1'($urandom), pick_ms());
   endfunction

   // Register settings per chunk: all on, active low, buzzer absent,
   // LED absent, outputs off, enabled with no pin at all.
   function automatic cfg_type chunk_setting(input int idx);
      case (idx)
         0:       return cfg_type'(4'b1111);
         1:       return cfg_type'(4'b1110);
         2:       return cfg_type'(4'b1011);
         3:       return cfg_type'(4'b1100);
         4:       return cfg_type'(4'b0111);
         default: return cfg_type'(4'b1001);
      endcase
   endfunction

   initial begin
      cfg_type c;
      int      n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part ---
      req_idle_pct = 0;
      rsp_idle_pct = 0;

      // reset settings leave the block disabled: both requests are ignored
      send_request(play_item(8'd2, 16'd0, 16'd1, 16'd0, 1'b1, 16'd2));
      send_request(tick_item());
      settle();

      write_settings(cfg_type'(4'b1111));
      // zero first-on time fires on the very next tick, zero gap likewise
      send_request(play_item(8'd2, 16'd0, 16'd1, 16'd0, 1'b1, 16'd2));
      repeat (6) send_request(tick_item());
      // all-ones extremes, then restart mid-pattern with zero pulses
      send_request(play_item(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF));
      repeat (2) send_request(tick_item());
      // zero pulses: not busy; zero hold keeps the LED lit
      send_request(play_item(8'd0, 16'd3, 16'd3, 16'd3, 1'b1, 16'd0));
      repeat (2) send_request(tick_item());
      settle();

      // buzzer absent, active low: sequence still runs, pin stays idle
      write_settings(cfg_type'(4'b1010));
      send_request(play_item(8'd3, 16'd1, 16'd1, 16'd1, 1'b1, 16'd3));
      repeat (4) send_request(tick_item());
      settle();

      // LED absent: hold timer armed but never lit, so it never disarms
      write_settings(cfg_type'(4'b1101));
      send_request(play_item(8'd1, 16'd2, 16'd0, 16'd0, 1'b1, 16'd1));
      repeat (3) send_request(tick_item());
      settle();

      // --- random part: three idle profiles, six register settings each ---
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin req_idle_pct = 7;  rsp_idle_pct = 65; end
            1: begin req_idle_pct = 65; rsp_idle_pct = 7;  end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int s = 0; s < 6; s++) begin
            c = chunk_setting(s);
            write_settings(c);
            n = (c.outputs_enabled && (c.buzzer_present || c.led_present)) ?
                ENABLED_CHUNK : IDLE_CHUNK;
            // long receiver hold-off while requests keep coming
            if (mode == 2 && s == 0) hold_off_go = 1'b1;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(99) < 7) send_request(random_play());
               else                        send_request(tick_item());
            end
            settle();
         end
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
